FILE: hw/rtl/utf8_scalar_decoder_assert.svh
// Assertion macros shared by the decoder RTL.
`ifndef UTF8_SCALAR_DECODER_ASSERT_SVH
`define UTF8_SCALAR_DECODER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define U8D_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define U8D_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/u8d_pkg.sv
// Shared types and constants of the UTF-8 scalar decoder.
package u8d_pkg;

  // Offset counter width; offsets wrap at this width.
  localparam int OFFSET_WIDTH = 32;
  localparam int OUT_OFS_W    = 32;

  // Job queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  typedef logic [OFFSET_WIDTH-1:0] offset_t;

  // Lead byte ranges
  localparam logic [7:0] LEAD2_LO = 8'hC2;
  localparam logic [7:0] LEAD2_HI = 8'hDF;
  localparam logic [7:0] LEAD3_LO = 8'hE0;
  localparam logic [7:0] LEAD3_HI = 8'hEF;
  localparam logic [7:0] LEAD4_LO = 8'hF0;
  localparam logic [7:0] LEAD4_HI = 8'hF4;
  localparam logic [1:0] CONT_TAG = 2'b10;

  // Scalar range limits
  localparam logic [20:0] MIN_W2   = 21'h80;
  localparam logic [20:0] MIN_W3   = 21'h800;
  localparam logic [20:0] MIN_W4   = 21'h10000;
  localparam logic [20:0] MAX_CP   = 21'h10FFFF;
  localparam logic [20:0] SURR_LO  = 21'hD800;
  localparam logic [20:0] SURR_HI  = 21'hDFFF;

  // Sequence widths
  localparam logic [2:0] W_NONE = 3'd0;
  localparam logic [2:0] W_ONE  = 3'd1;
  localparam logic [2:0] W_TWO  = 3'd2;
  localparam logic [2:0] W_THREE = 3'd3;
  localparam logic [2:0] W_FOUR = 3'd4;

  // Result kinds
  localparam logic KIND_VALID = 1'b0;
  localparam logic KIND_BAD   = 1'b1;

  // One job: a run of bad bytes from base, then optionally one valid scalar
  // whose offset is base + bad_cnt.
  typedef struct packed {
    logic [2:0]  bad_cnt;
    logic        has_valid;
    offset_t     base;
    logic [20:0] scalar;
    logic [2:0]  len;
  } job_t;

endpackage

FILE: hw/rtl/utf8_scalar_decoder.sv
// Streaming UTF-8 decoder: one byte in per cycle while the job queue is not full,
// one result out per cycle while the output is not stalled. A result passes through
// the job queue and then the back end's output register. A byte may cause several
// results; the four-job queue absorbs bursts, so the output port sets the pace.
// Reset (rst, synchronous) empties the queue and clears all sequence state.
module utf8_scalar_decoder
  import u8d_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           byte_in,
  input  logic                 is_final,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 kind,
  output logic [20:0]          scalar,
  output logic [2:0]           seq_len,
  output logic [OUT_OFS_W-1:0] start_offset,
  output logic                 last_of_run
);

  job_t push_job;
  job_t head;
  logic push;
  logic pop;
  logic empty;
  logic full;

  u8d_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .byte_in  (byte_in),
    .is_final (is_final),
    .full     (full),
    .push     (push),
    .job      (push_job)
  );

  u8d_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  u8d_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .scalar       (scalar),
    .seq_len      (seq_len),
    .start_offset (start_offset),
    .last_of_run  (last_of_run)
  );

endmodule

FILE: hw/rtl/u8d_front.sv
// Front end: accepts bytes, tracks the open sequence and issues result jobs.
`include "utf8_scalar_decoder_assert.svh"
module u8d_front
  import u8d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] byte_in,
  input  logic       is_final,
  input  logic       full,
  output logic       push,
  output job_t       job
);

  logic [2:0]  pw, pw_next;
  logic [1:0]  held, held_next;
  logic [20:0] pv, pv_next;
  offset_t     seq_start, seq_start_next;
  offset_t     pos, pos_next;
  logic        accept;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  // Decode of one byte against the open sequence
  always_comb begin
    logic        is_cont;
    logic        pending;
    logic [2:0]  held_inc;
    logic [20:0] pv_cat;
    logic [20:0] min_cp;
    logic        range_bad;
    logic        complete;
    logic [2:0]  lead_w;
    logic [20:0] lead_bits;
    logic [2:0]  cnt0;

    is_cont  = (byte_in[7:6] == CONT_TAG);
    pending  = (pw != W_NONE);
    held_inc = {1'b0, held} + 3'd1;
    pv_cat   = {pv[14:0], byte_in[5:0]};
    complete = (held_inc + 3'd1) >= pw;

    case (pw)
      W_TWO:   min_cp = MIN_W2;
      W_THREE: min_cp = MIN_W3;
      default: min_cp = MIN_W4;
    endcase
    range_bad = (pv_cat < min_cp) || (pv_cat > MAX_CP) ||
                ((pv_cat >= SURR_LO) && (pv_cat <= SURR_HI));

    // lead byte class
    if (byte_in >= LEAD2_LO && byte_in <= LEAD2_HI) begin
      lead_w    = W_TWO;
      lead_bits = {16'd0, byte_in[4:0]};
    end else if (byte_in >= LEAD3_LO && byte_in <= LEAD3_HI) begin
      lead_w    = W_THREE;
      lead_bits = {17'd0, byte_in[3:0]};
    end else if (byte_in >= LEAD4_LO && byte_in <= LEAD4_HI) begin
      lead_w    = W_FOUR;
      lead_bits = {18'd0, byte_in[2:0]};
    end else begin
      lead_w    = W_NONE;
      lead_bits = '0;
    end

    job.bad_cnt   = 3'd0;
    job.has_valid = 1'b0;
    job.base      = pos;
    job.scalar    = '0;
    job.len       = W_ONE;
    cnt0          = 3'd0;

    pw_next        = pw;
    held_next      = held;
    pv_next        = pv;
    seq_start_next = seq_start;
    pos_next       = pos + offset_t'(1);

    if (pending && is_cont) begin
      // continuation byte of the open sequence
      held_next = held_inc[1:0];
      pv_next   = pv_cat;
      job.base  = seq_start;
      if (complete) begin
        pw_next   = W_NONE;
        held_next = 2'd0;
        pv_next   = '0;
        if (range_bad) begin
          job.bad_cnt = pw;
        end else begin
          job.has_valid = 1'b1;
          job.scalar    = pv_cat;
          job.len       = pw;
        end
      end else if (is_final) begin
        job.bad_cnt = held_inc + 3'd1;
      end
    end else begin
      // broken sequence flushes first; the bad bytes are contiguous with pos
      if (pending) begin
        cnt0      = {1'b0, held} + 3'd1;
        job.base  = seq_start;
        pw_next   = W_NONE;
        held_next = 2'd0;
        pv_next   = '0;
      end
      job.bad_cnt = cnt0;
      if (!byte_in[7]) begin
        job.has_valid = 1'b1;
        job.scalar    = {13'd0, byte_in};
      end else if (lead_w != W_NONE) begin
        if (is_final) begin
          job.bad_cnt = cnt0 + 3'd1;
        end else begin
          pw_next        = lead_w;
          held_next      = 2'd0;
          pv_next        = lead_bits;
          seq_start_next = pos;
        end
      end else begin
        job.bad_cnt = cnt0 + 3'd1;
      end
    end

    // end of source: back to the reset state
    if (is_final) begin
      pw_next        = W_NONE;
      held_next      = 2'd0;
      pv_next        = '0;
      seq_start_next = '0;
      pos_next       = '0;
    end

    push = accept && ((job.bad_cnt != 3'd0) || job.has_valid);
  end

  // Sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      pw        <= W_NONE;
      held      <= 2'd0;
      pv        <= '0;
      seq_start <= '0;
      pos       <= '0;
    end else if (accept) begin
      pw        <= pw_next;
      held      <= held_next;
      pv        <= pv_next;
      seq_start <= seq_start_next;
      pos       <= pos_next;
    end
  end

  `U8D_ASSERT_NXT(a_final_clears, clk, rst, accept && is_final, (pw == W_NONE) && (pos == '0), "state not cleared after final byte")
  `U8D_ASSERT_IMP(a_held_below_width, clk, rst, pw != W_NONE, ({1'b0, held} + 3'd1) < pw, "held count reached sequence width")

endmodule

FILE: hw/rtl/u8d_queue.sv
// Short job queue between the front and back ends.
`include "utf8_scalar_decoder_assert.svh"
module u8d_queue
  import u8d_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic empty,
  output logic full
);

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign empty   = (count == '0);
  assign full    = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `U8D_ASSERT_IMP(a_pop_not_empty, clk, rst, pop, !empty, "pop from empty job queue")

endmodule

FILE: hw/rtl/u8d_back.sv
// Back end: expands each job into result transactions through an output register.
`include "utf8_scalar_decoder_assert.svh"
module u8d_back
  import u8d_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  job_t                 head,
  input  logic                 empty,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 kind,
  output logic [20:0]          scalar,
  output logic [2:0]           seq_len,
  output logic [OUT_OFS_W-1:0] start_offset,
  output logic                 last_of_run
);

  logic [1:0]  idx;
  logic        load;
  logic [2:0]  n_total;
  logic        cur_bad;
  logic        cur_last;
  offset_t     cur_ofs;

  // Current result of the head job
  assign n_total  = head.bad_cnt + {2'd0, head.has_valid};
  assign cur_bad  = {1'b0, idx} < head.bad_cnt;
  assign cur_last = ({1'b0, idx} + 3'd1) == n_total;
  assign cur_ofs  = head.base + offset_t'(idx);
  assign load     = !empty && (!out_valid || out_ready);
  assign pop      = load && cur_last;

  // Position within the job
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (load) begin
      idx <= cur_last ? 2'd0 : idx + 2'd1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind         <= cur_bad ? KIND_BAD : KIND_VALID;
      scalar       <= cur_bad ? 21'd0 : head.scalar;
      seq_len      <= cur_bad ? W_ONE : head.len;
      start_offset <= OUT_OFS_W'(cur_ofs);
      last_of_run  <= cur_last;
    end
  end

  `U8D_ASSERT_IMP(a_bad_shape, clk, rst, out_valid && (kind == KIND_BAD), (scalar == 21'd0) && (seq_len == W_ONE), "bad byte result malformed")
  `U8D_ASSERT_IMP(a_valid_len, clk, rst, out_valid && (kind == KIND_VALID), (seq_len != W_NONE) && (seq_len <= W_FOUR), "scalar length out of range")

endmodule

FILE: dv/utf8_scalar_decoder_test.sv
// Self-checking random and directed testbench for utf8_scalar_decoder.
module utf8_scalar_decoder_test
  import u8d_pkg::*;
;

  localparam int RUN_LIMIT    = 400000;
  localparam int RANDOM_BYTES = 290;
  localparam int HOLD_CYCLES  = 160;
  localparam int HOLD_AT      = 250;

  // One decoded result as seen on the output port
  typedef struct {
    logic                 kind;
    logic [20:0]          cp;
    logic [2:0]           len;
    logic [OUT_OFS_W-1:0] ofs;
    logic                 last;
  } scalar_res_t;

  typedef enum int {RX_OPEN, RX_HALF, RX_MOSTLY, RX_SPARSE} rx_mode_t;

  // Leads whose completions often fall out of range
  localparam logic [7:0] EDGE_LEADS [4] = '{8'hE0, 8'hED, 8'hF0, 8'hF4};

  // Tracks decoder state and the results still owed by the block
  class utf8_decode_board;
    logic [2:0]  open_width;
    logic [1:0]  conts_held;
    logic [20:0] partial;
    offset_t     lead_ofs;
    offset_t     next_ofs;
    scalar_res_t due[$];
    scalar_res_t run[$];
    int          errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void clear_open();
      open_width = W_NONE;
      conts_held = '0;
      partial    = '0;
    endfunction

    function void restart();
      clear_open();
      lead_ofs = '0;
      next_ofs = '0;
    endfunction

    function void emit(logic k, logic [20:0] cp, logic [2:0] len, offset_t ofs);
      scalar_res_t r;
      r.kind = k;
      r.cp   = cp;
      r.len  = len;
      r.ofs  = OUT_OFS_W'(ofs);
      r.last = 1'b0;
      run.push_back(r);
    endfunction

    // Lead and every held continuation come out as single bad bytes
    function void drop_open();
      emit(KIND_BAD, '0, W_ONE, lead_ofs);
      for (int k = 1; k <= int'(conts_held); k++)
        emit(KIND_BAD, '0, W_ONE, lead_ofs + offset_t'(k));
      clear_open();
    endfunction

    function void byte_taken(logic [7:0] b, logic fin);
      offset_t     pos;
      logic        took;
      logic [20:0] floor_cp;
      run.delete();
      pos  = next_ofs;
      took = 1'b0;

      // Continue or break an open sequence
      if (open_width != W_NONE) begin
        if (b[7:6] == CONT_TAG) begin
          took       = 1'b1;
          partial    = {partial[14:0], b[5:0]};
          conts_held = conts_held + 2'd1;
          if (int'(conts_held) + 1 >= int'(open_width)) begin
            floor_cp = (open_width == W_TWO)   ? MIN_W2 :
                       (open_width == W_THREE) ? MIN_W3 : MIN_W4;
            if (partial < floor_cp || partial > MAX_CP ||
                (partial >= SURR_LO && partial <= SURR_HI)) begin
              drop_open();
            end else begin
              emit(KIND_VALID, partial, open_width, lead_ofs);
              clear_open();
            end
          end
        end else begin
          drop_open();
        end
      end

      // Fresh decode of a byte not absorbed above
      if (!took) begin
        if (b < 8'h80) begin
          emit(KIND_VALID, {13'd0, b}, W_ONE, pos);
        end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
          open_width = W_TWO;
          partial    = {16'd0, b[4:0]};
        end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
          open_width = W_THREE;
          partial    = {17'd0, b[3:0]};
        end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
          open_width = W_FOUR;
          partial    = {18'd0, b[2:0]};
        end else begin
          emit(KIND_BAD, '0, W_ONE, pos);
        end
        if (open_width != W_NONE && b >= 8'h80) begin
          conts_held = '0;
          lead_ofs   = pos;
        end
      end

      next_ofs = pos + offset_t'(1);

      // End of source: flush what is open and start again from offset zero
      if (fin) begin
        if (open_width != W_NONE)
          drop_open();
        restart();
      end

      if (run.size() > 0)
        run[run.size()-1].last = 1'b1;
      foreach (run[i])
        due.push_back(run[i]);
    endfunction

    function void compare_field(string what, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        errors++;
      end
    endfunction

    function void result_seen(logic k, logic [20:0] cp, logic [2:0] len,
                              logic [OUT_OFS_W-1:0] ofs, logic last);
      scalar_res_t want;
      if (due.size() == 0) begin
        $display("%0t: unexpected result kind=%0h scalar=%0h len=%0h offset=%0h last=%0h",
                 $time, k, cp, len, ofs, last);
        errors++;
        return;
      end
      want = due.pop_front();
      compare_field("kind", 32'(want.kind), 32'(k));
      compare_field("scalar", 32'(want.cp), 32'(cp));
      compare_field("seq_len", 32'(want.len), 32'(len));
      compare_field("start_offset", 32'(want.ofs), 32'(ofs));
      compare_field("last_of_run", 32'(want.last), 32'(last));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           byte_in = 8'h00;
  logic                 is_final = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 kind;
  logic [20:0]          scalar;
  logic [2:0]           seq_len;
  logic [OUT_OFS_W-1:0] start_offset;
  logic                 last_of_run;

  utf8_decode_board board = new();
  logic [7:0]       plan[$];
  int               burst_left = 0;
  int               bytes_sent = 0;
  int               cycles = 0;

  utf8_scalar_decoder DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .byte_in      (byte_in),
    .is_final     (is_final),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .scalar       (scalar),
    .seq_len      (seq_len),
    .start_offset (start_offset),
    .last_of_run  (last_of_run)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("run timed out after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Output monitor: every transaction goes to the board
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.result_seen(kind, scalar, seq_len, start_offset, last_of_run);
  end

  // Sender: bursts of random length with random gaps between them
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    byte_in  <= b;
    is_final <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.byte_taken(b, fin);
    bytes_sent++;
  endtask

  // Sends the planned bytes as one source, final flag on the last
  task automatic send_plan();
    foreach (plan[i])
      send_byte(plan[i], i == plan.size() - 1);
    plan.delete();
  endtask

  // Appends one character: mostly well formed, some noise and broken forms
  function automatic void plan_char();
    int          pick;
    int          w;
    logic [20:0] cp;
    logic [7:0]  lead;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      plan.push_back(8'($urandom_range(0, 127)));
    end else if (pick < 52) begin
      cp = 21'($urandom_range(21'h80, 21'h7FF));
      plan.push_back({3'b110, cp[10:6]});
      plan.push_back({2'b10, cp[5:0]});
    end else if (pick < 68) begin
      cp = 21'($urandom_range(21'h800, 21'hFFFF));
      if (cp >= SURR_LO && cp <= SURR_HI)
        cp = cp ^ 21'h2000;
      plan.push_back({4'b1110, cp[15:12]});
      plan.push_back({2'b10, cp[11:6]});
      plan.push_back({2'b10, cp[5:0]});
    end else if (pick < 80) begin
      cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
      plan.push_back({5'b11110, cp[20:18]});
      plan.push_back({2'b10, cp[17:12]});
      plan.push_back({2'b10, cp[11:6]});
      plan.push_back({2'b10, cp[5:0]});
    end else if (pick < 87) begin
      plan.push_back(8'($urandom_range(0, 255)));
    end else begin
      // lead with random continuation content, full or cut short
      lead = ($urandom_range(0, 1) == 1) ? EDGE_LEADS[$urandom_range(0, 3)]
                                         : 8'($urandom_range(8'hC2, 8'hF4));
      w = (lead >= LEAD4_LO) ? 4 : (lead >= LEAD3_LO) ? 3 : 2;
      if (pick >= 94)
        w = $urandom_range(1, w - 1);
      plan.push_back(lead);
      repeat (w - 1) plan.push_back({2'b10, 6'($urandom)});
    end
  endfunction

  // Receiver: own ready pattern, plus one long hold-off to back up the block
  initial begin : receiver
    rx_mode_t mode;
    int       span;
    int       seen;
    logic     held_off;
    held_off = 1'b0;
    seen     = 0;
    while (rst) @(posedge clk);
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(8, 60);
      repeat (span) begin
        @(posedge clk);
        seen++;
        if (!held_off && seen >= HOLD_AT) begin
          held_off = 1'b1;
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end else begin
          case (mode)
            RX_OPEN:   out_ready <= 1'b1;
            RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
            RX_MOSTLY: out_ready <= ($urandom_range(0, 9) != 0);
            default:   out_ready <= ($urandom_range(0, 4) == 0);
          endcase
        end
      end
    end
  end

  // Main stimulus
  initial begin : stimulus
    int nchars;
    int rand_start;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // ASCII extremes, stray bytes, smallest two-byte, surrogate, above range,
    // overlong, broken sequence, largest scalar, then truncation at the end
    plan = {8'h00, 8'h7F, 8'h80, 8'hC1, 8'hF5, 8'hC2, 8'h80, 8'hED, 8'hA0, 8'h80,
            8'hF4, 8'h90, 8'h80, 8'h80, 8'hE0, 8'h9F, 8'hBF, 8'hE2, 8'h82, 8'h41,
            8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hF0, 8'h90};
    send_plan();
    // final flag on a bare lead, then on a stray byte
    plan.push_back(8'hC3);
    send_plan();
    plan.push_back(8'hFF);
    send_plan();

    // Random sources of mixed characters
    rand_start = bytes_sent;
    while (bytes_sent - rand_start < RANDOM_BYTES) begin
      nchars = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      repeat (nchars) plan_char();
      send_plan();
    end
    in_valid <= 1'b0;

    // Drain, then allow for the pipeline latency
    while (board.due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (board.errors == 0 && board.due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: utf8_scalar_decoder.f
+incdir+hw/rtl
hw/rtl/u8d_pkg.sv
hw/rtl/u8d_front.sv
hw/rtl/u8d_queue.sv
hw/rtl/u8d_back.sv
hw/rtl/utf8_scalar_decoder.sv
dv/utf8_scalar_decoder_test.sv
